FILE: hw/rtl/spta_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the sky-plane texel addresser.
package spta_pkg;

   localparam int WORD_W      = 32;
   localparam int TRIG_W      = 18;
   localparam int SCALE_W     = 31;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = WORD_W + TRIG_W;
   localparam int CSR_INDEX_W = 3;
   localparam int TEXEL_W     = 16;
   localparam int TEXEL_LSB   = 13;
   localparam int BYTE_W      = 8;
   localparam int SCALE_SHIFT = 2;

   localparam logic [WORD_W-1:0]  ROUND_HALF    = 32'h0000_8000;
   localparam logic [TRIG_W-1:0]  COSINE_RESET  = 18'h1_0000;
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 31'h0001_0000;
   localparam int                 CENTER_RESET  = 160;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_X,
      CSR_VIEW_Y,
      CSR_VIEW_SINE,
      CSR_VIEW_COSINE,
      CSR_DRIFT_X,
      CSR_DRIFT_Y,
      CSR_PROJECTION_SCALE,
      CSR_CENTER_COLUMN
   } csr_index_type;

   // Rounds a 16.16 product to nearest (ties upward) and keeps 32 bits.
   function automatic logic [WORD_W-1:0] fmul_round(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] r;
      r = p + PROD_W'(ROUND_HALF);
      return r[FRAC_W+WORD_W-1:FRAC_W];
   endfunction

endpackage

FILE: hw/rtl/sky_plane_texel_address_top.sv
// Pipelined sky-plane texel address generator with its configuration registers.
//
// Usage: each request on the req_ channel carries one sky pixel (screen column and row
// distance from the horizon); the rsp_ channel returns one 16-bit texel index per request,
// in request order. Registers are loaded through the csr_ write port, one per clock with
// csr_we high; the user must write them only while no request is in flight, as the block
// does not enforce it. Throughput is one request per clock while rsp_ does not stall;
// most of the pipeline depth is set by the two long dividers, six stages of eight
// quotient bits for the row division and 32 one-bit stages for the scale division.
// Reset returns all registers to their defaults and empties the pipeline.
// When the receiver stalls, the output register holds its result and the pipeline keeps
// accepting requests until an item reaches the last stage; then the whole pipeline holds
// and req_tready drops, so no request is lost or repeated.
module sky_plane_texel_address_top #(
   parameter int MAX_COLUMNS    = 1024,
   parameter int MAX_ROW_HEIGHT = 512,
   localparam int COL_W = $clog2(MAX_COLUMNS),
   localparam int H_W   = $clog2(MAX_ROW_HEIGHT),
   localparam int REQ_W = ((COL_W + H_W + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_W-1:0]                    req_tdata,   // column, row_height
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [spta_pkg::TEXEL_W-1:0]        rsp_tdata,   // texel_index
   input  logic                                csr_we,
   input  logic [spta_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spta_pkg::WORD_W-1:0]         csr_wdata
);
   import spta_pkg::*;

   localparam int D1_STEPS  = 8;
   localparam int D1_BITS   = SCALE_W + FRAC_W;
   localparam int D1_STAGES = (D1_BITS + D1_STEPS - 1) / D1_STEPS;
   localparam int D1_PAD    = D1_STAGES * D1_STEPS;
   localparam int D2_STAGES = WORD_W;
   localparam int P_POS     = D1_STAGES;
   localparam int F_POS     = P_POS + 1 + D2_STAGES;
   localparam int G_POS     = F_POS + 1;
   localparam int H_POS     = G_POS + 1;
   localparam int I_POS     = H_POS + 1;
   localparam int N_STAGES  = I_POS + 1;
   localparam int D_W       = COL_W + 1;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [H_W-1:0]    h;
      logic [H_W-1:0]    rem;
      logic [WORD_W-1:0] quo;
   } div1_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [WORD_W-1:0] bd;
      logic [WORD_W-1:0] mag;
      logic              neg;
   } prep_type;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [WORD_W-1:0]  bd;
      logic               neg;
      logic [WORD_W-1:0]  mag;
      logic [SCALE_W-1:0] rem;
      logic [WORD_W-1:0]  quo;
   } div2_type;

   typedef struct packed {
      logic [D_W-1:0]    d;
      logic [WORD_W-1:0] ss;
      logic [PROD_W-1:0] px;
      logic [PROD_W-1:0] py;
   } fstage_type;

   typedef struct packed {
      logic [D_W-1:0]    d;
      logic [PROD_W-1:0] xp;
      logic [PROD_W-1:0] yp;
      logic [WORD_W-1:0] fx;
      logic [WORD_W-1:0] fy;
   } gstage_type;

   typedef struct packed {
      logic [D_W-1:0]    d;
      logic [WORD_W-1:0] xstep;
      logic [WORD_W-1:0] ystep;
      logic [WORD_W-1:0] ax;
      logic [WORD_W-1:0] ay;
   } hstage_type;

   typedef struct packed {
      logic [WORD_W-1:0] ax;
      logic [WORD_W-1:0] ay;
      logic [WORD_W-1:0] mx;
      logic [WORD_W-1:0] my;
   } istage_type;

   logic [WORD_W-1:0]  view_x_ff, view_y_ff, drift_x_ff, drift_y_ff;
   logic [TRIG_W-1:0]  view_sine_ff, view_cosine_ff;
   logic [SCALE_W-1:0] projection_scale_ff;
   logic [COL_W-1:0]   center_column_ff;

   logic [N_STAGES-1:0] v_ff, v_in;
   logic                adv, out_load;

   div1_type   div1_src [D1_STAGES];
   div1_type   div1_in  [D1_STAGES];
   div1_type   div1_ff  [D1_STAGES];
   prep_type   p_in, p_ff;
   div2_type   div2_src [D2_STAGES];
   div2_type   div2_in  [D2_STAGES];
   div2_type   div2_ff  [D2_STAGES];
   fstage_type f_in, f_ff;
   gstage_type g_in, g_ff;
   hstage_type h_in, h_ff;
   istage_type i_in, i_ff;

   logic                rsp_tvalid_ff;
   logic [TEXEL_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff           <= '0;
         view_y_ff           <= '0;
         view_sine_ff        <= '0;
         view_cosine_ff      <= COSINE_RESET;
         drift_x_ff          <= '0;
         drift_y_ff          <= '0;
         projection_scale_ff <= SCALE_RESET;
         center_column_ff    <= COL_W'(CENTER_RESET);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW_X:           view_x_ff           <= csr_wdata;
            CSR_VIEW_Y:           view_y_ff           <= csr_wdata;
            CSR_VIEW_SINE:        view_sine_ff        <= csr_wdata[TRIG_W-1:0];
            CSR_VIEW_COSINE:      view_cosine_ff      <= csr_wdata[TRIG_W-1:0];
            CSR_DRIFT_X:          drift_x_ff          <= csr_wdata;
            CSR_DRIFT_Y:          drift_y_ff          <= csr_wdata;
            CSR_PROJECTION_SCALE: projection_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_CENTER_COLUMN:    center_column_ff    <= csr_wdata[COL_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign adv        = !v_ff[I_POS] || out_load;
   assign req_tready = adv;
   assign v_in       = {v_ff[N_STAGES-2:0], req_tvalid};

   // The scale shifted up by 16 is divided by the row height, eight quotient bits per stage.
   always_comb begin
      div1_type            s;
      logic [H_W:0]        t;
      logic [D1_STEPS-1:0] chunk;
      logic [D1_PAD-1:0]   dividend;
      dividend    = D1_PAD'({projection_scale_ff, FRAC_W'(0)});
      div1_src[0] = '{col: req_tdata[COL_W-1:0], h: req_tdata[COL_W+H_W-1:COL_W],
                      rem: '0, quo: '0};
      for (int k = 1; k < D1_STAGES; k++) begin
         div1_src[k] = div1_ff[k-1];
      end
      for (int k = 0; k < D1_STAGES; k++) begin
         s     = div1_src[k];
         chunk = D1_STEPS'(dividend >> ((D1_STAGES - 1 - k) * D1_STEPS));
         for (int j = 0; j < D1_STEPS; j++) begin
            t     = {s.rem, chunk[D1_STEPS-1]};
            chunk = {chunk[D1_STEPS-2:0], 1'b0};
            if (t >= {1'b0, s.h}) begin
               t     = t - {1'b0, s.h};
               s.quo = {s.quo[WORD_W-2:0], 1'b1};
            end else begin
               s.quo = {s.quo[WORD_W-2:0], 1'b0};
            end
            s.rem = t[H_W-1:0];
         end
         div1_in[k] = s;
      end
   end

   always_comb begin
      logic [WORD_W-1:0] q;
      logic [WORD_W-1:0] bd;
      q        = (div1_ff[D1_STAGES-1].h == '0) ? '0 : div1_ff[D1_STAGES-1].quo;
      bd       = q << SCALE_SHIFT;
      p_in.col = div1_ff[D1_STAGES-1].col;
      p_in.bd  = bd;
      p_in.neg = bd[WORD_W-1];
      p_in.mag = bd[WORD_W-1] ? (WORD_W'(0) - bd) : bd;
   end

   // Magnitude of the base distance divided by the scale, one quotient bit per stage.
   always_comb begin
      div2_type       s;
      logic [SCALE_W:0] t;
      div2_src[0] = '{col: p_ff.col, bd: p_ff.bd, neg: p_ff.neg, mag: p_ff.mag,
                      rem: '0, quo: '0};
      for (int k = 1; k < D2_STAGES; k++) begin
         div2_src[k] = div2_ff[k-1];
      end
      for (int k = 0; k < D2_STAGES; k++) begin
         s     = div2_src[k];
         t     = {s.rem, s.mag[WORD_W-1]};
         s.mag = {s.mag[WORD_W-2:0], 1'b0};
         if (t >= {1'b0, projection_scale_ff}) begin
            t     = t - {1'b0, projection_scale_ff};
            s.quo = {s.quo[WORD_W-2:0], 1'b1};
         end else begin
            s.quo = {s.quo[WORD_W-2:0], 1'b0};
         end
         s.rem      = t[SCALE_W-1:0];
         div2_in[k] = s;
      end
   end

   always_comb begin
      div2_type l;
      l       = div2_ff[D2_STAGES-1];
      f_in.d  = {1'b0, l.col} - {1'b0, center_column_ff} - D_W'(1);
      if (projection_scale_ff == '0) begin
         f_in.ss = '0;
      end else begin
         f_in.ss = l.neg ? (WORD_W'(0) - l.quo) : l.quo;
      end
      f_in.px = PROD_W'($signed(l.bd)) * PROD_W'($signed(view_cosine_ff));
      f_in.py = PROD_W'($signed(l.bd)) * PROD_W'($signed(view_sine_ff));
   end

   always_comb begin
      g_in.d  = f_ff.d;
      g_in.xp = PROD_W'($signed(f_ff.ss)) * PROD_W'($signed(view_sine_ff));
      g_in.yp = PROD_W'($signed(f_ff.ss)) * PROD_W'($signed(view_cosine_ff));
      g_in.fx = fmul_round(f_ff.px);
      g_in.fy = fmul_round(f_ff.py);
   end

   always_comb begin
      h_in.d     = g_ff.d;
      h_in.xstep = fmul_round(g_ff.xp);
      h_in.ystep = WORD_W'(0) - fmul_round(g_ff.yp);
      h_in.ax    = view_x_ff + g_ff.fx + drift_x_ff;
      h_in.ay    = g_ff.fy + drift_y_ff - view_y_ff;
   end

   always_comb begin
      i_in.ax = h_ff.ax;
      i_in.ay = h_ff.ay;
      i_in.mx = h_ff.xstep * WORD_W'($signed(h_ff.d));
      i_in.my = h_ff.ystep * WORD_W'($signed(h_ff.d));
   end

   always_comb begin
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      x            = i_ff.ax + i_ff.mx;
      y            = i_ff.ay + i_ff.my;
      rsp_tdata_in = {x[TEXEL_LSB+BYTE_W-1:TEXEL_LSB], ~y[TEXEL_LSB+BYTE_W-1:TEXEL_LSB]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < D1_STAGES; k++) begin
            div1_ff[k] <= div1_in[k];
         end
         p_ff <= p_in;
         for (int k = 0; k < D2_STAGES; k++) begin
            div2_ff[k] <= div2_in[k];
         end
         f_ff <= f_in;
         g_ff <= g_in;
         h_ff <= h_in;
         i_ff <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= v_ff[I_POS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (v_ff == '0) && !rsp_tvalid_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[I_POS] && !req_tready |=> v_ff[I_POS] && $stable(i_ff))
      else $error("last stage changed during a stall");

   a_row_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[D1_STAGES-1] && (div1_ff[D1_STAGES-1].h != '0)
         |-> div1_ff[D1_STAGES-1].rem < div1_ff[D1_STAGES-1].h)
      else $error("row divider remainder out of range");

   a_scale_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[F_POS-1] && (projection_scale_ff != '0)
         |-> div2_ff[D2_STAGES-1].rem < projection_scale_ff)
      else $error("scale divider remainder out of range");

endmodule

FILE: sim/tb_sky_plane_texel_address_top.sv
`timescale 1ns / 100ps
// Self-checking testbench that streams sky pixels through the texel addresser and checks every index.
module tb_sky_plane_texel_address_top;
   import spta_pkg::*;

   localparam int REQ_BITS      = 24;
   localparam int PIPE_DEPTH    = 43;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_OFF      = 300;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ITEMS   = 90;
   localparam int CHOKE_PHASE   = 4;
   localparam int PROBE_ROWS    = 20;
   localparam logic [TEXEL_W-1:0] EMPTY_TEXEL = 16'h00ff;

   typedef struct {
      logic [WORD_W-1:0]  view_x;
      logic [WORD_W-1:0]  view_y;
      logic [TRIG_W-1:0]  sine;
      logic [TRIG_W-1:0]  cosine;
      logic [WORD_W-1:0]  drift_x;
      logic [WORD_W-1:0]  drift_y;
      logic [SCALE_W-1:0] scale;
      logic [9:0]         center;
   } sky_view_type;

   typedef struct {
      logic [9:0]         column;
      logic [8:0]         row_height;
      bit                 typed;
      logic [TEXEL_W-1:0] texel;
   } probe_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_BITS-1:0]    req_tdata;   // column, row_height
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TEXEL_W-1:0]     rsp_tdata;   // texel_index
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   bit                     req_typed;
   logic [TEXEL_W-1:0]     req_typed_texel;
   bit                     stall_enable;
   bit                     choke_request;
   int                     fault_count = 0;
   int                     cycle_count;
   sky_view_type           view_copy;
   logic [TEXEL_W-1:0]     texel_queue[$];

   // At reset settings, row heights 0, 1, 2 and 4 give a zero base distance.
   probe_row_type probe_table [PROBE_ROWS] = '{
      '{10'd0,    9'd1,   1'b1, EMPTY_TEXEL},
      '{10'd1023, 9'd0,   1'b1, EMPTY_TEXEL},
      '{10'd160,  9'd2,   1'b1, EMPTY_TEXEL},
      '{10'd161,  9'd4,   1'b1, EMPTY_TEXEL},
      '{10'd1023, 9'd1,   1'b1, EMPTY_TEXEL},
      '{10'd0,    9'd0,   1'b1, EMPTY_TEXEL},
      '{10'd0,    9'd511, 1'b0, 16'h0},
      '{10'd1023, 9'd511, 1'b0, 16'h0},
      '{10'd159,  9'd3,   1'b0, 16'h0},
      '{10'd160,  9'd8,   1'b0, 16'h0},
      '{10'd161,  9'd256, 1'b0, 16'h0},
      '{10'd682,  9'd341, 1'b0, 16'h0},
      '{10'd341,  9'd170, 1'b0, 16'h0},
      '{10'd512,  9'd255, 1'b0, 16'h0},
      '{10'd0,    9'd5,   1'b0, 16'h0},
      '{10'd1023, 9'd7,   1'b0, 16'h0},
      '{10'd161,  9'd64,  1'b0, 16'h0},
      '{10'd159,  9'd100, 1'b0, 16'h0},
      '{10'd320,  9'd16,  1'b0, 16'h0},
      '{10'd800,  9'd33,  1'b0, 16'h0}
   };

   sky_plane_texel_address_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic sky_view_type default_view();
      sky_view_type v;
      v.view_x  = '0;
      v.view_y  = '0;
      v.sine    = '0;
      v.cosine  = COSINE_RESET;
      v.drift_x = '0;
      v.drift_y = '0;
      v.scale   = SCALE_RESET;
      v.center  = 10'(CENTER_RESET);
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] round_mul(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return WORD_W'(p >>> FRAC_W);
   endfunction

   function automatic logic [TEXEL_W-1:0] texel_of(sky_view_type v, logic [9:0] column,
                                                  logic [8:0] row_height);
      logic [63:0]       quot_wide;
      logic [WORD_W-1:0] quot, base_dist, x_step, y_step, offset, x, y;
      longint            base_s, step_s, sine_s, cosine_s;
      quot = '0;
      if (row_height != 0) begin
         quot_wide = 64'(v.scale) << FRAC_W;
         quot_wide = quot_wide / 64'(row_height);
         quot = quot_wide[WORD_W-1:0];
      end
      base_dist = quot << SCALE_SHIFT;
      base_s = $signed(base_dist);
      step_s = 0;
      if (v.scale != 0)
         step_s = base_s / longint'(v.scale);
      sine_s = $signed(v.sine);
      cosine_s = $signed(v.cosine);
      x_step = round_mul(step_s, sine_s);
      y_step = 32'd0 - round_mul(step_s, cosine_s);
      offset = 32'(column) - 32'(v.center) - 32'd1;
      x = v.view_x + round_mul(base_s, cosine_s) + v.drift_x + x_step * offset;
      y = (32'd0 - (v.view_y - round_mul(base_s, sine_s) - v.drift_y)) + y_step * offset;
      return {x[TEXEL_LSB +: BYTE_W], ~y[TEXEL_LSB +: BYTE_W]};
   endfunction

   function automatic logic [TRIG_W-1:0] random_trig();
      int angle;
      angle = int'($urandom_range(0, 131072)) - 65536;
      if ($urandom_range(0, 5) == 0)
         return TRIG_W'($urandom);
      return TRIG_W'(angle);
   endfunction

   function automatic sky_view_type random_view();
      sky_view_type v;
      v.view_x  = $urandom;
      v.view_y  = $urandom;
      v.sine    = random_trig();
      v.cosine  = random_trig();
      v.drift_x = $urandom;
      v.drift_y = $urandom;
      case ($urandom_range(0, 3))
         0: v.scale = SCALE_W'($urandom_range(1, 32'h7fff_ffff));
         1: v.scale = SCALE_W'($urandom_range(1, 32'h0004_0000));
         2: v.scale = SCALE_W'($urandom_range(32'h0000_8000, 32'h0010_0000));
         default: v.scale = SCALE_RESET;
      endcase
      v.center = 10'($urandom_range(0, 1023));
      return v;
   endfunction

   function automatic sky_view_type fixed_view(int phase);
      sky_view_type v;
      v = default_view();
      case (phase)
         1: begin
            v.view_x  = 32'h7fff_ffff;
            v.view_y  = 32'h8000_0000;
            v.sine    = 18'h3_0000;
            v.cosine  = 18'h1_0000;
            v.drift_x = 32'h8000_0000;
            v.drift_y = 32'h7fff_ffff;
            v.scale   = 31'h7fff_ffff;
            v.center  = 10'd1023;
         end
         2: begin
            v.view_x  = 32'hffff_ffff;
            v.view_y  = 32'h0001_2345;
            v.sine    = 18'h1_0000;
            v.cosine  = 18'h3_0000;
            v.drift_x = 32'h0000_0000;
            v.drift_y = 32'hffff_ffff;
            v.scale   = '0;
            v.center  = 10'd0;
         end
         default: begin
            v.view_x  = 32'h8000_0000;
            v.view_y  = 32'h7fff_ffff;
            v.sine    = 18'h1_ffff;
            v.cosine  = 18'h2_0000;
            v.drift_x = 32'h7fff_ffff;
            v.drift_y = 32'h8000_0000;
            v.scale   = 31'd1;
            v.center  = 10'd512;
         end
      endcase
      return v;
   endfunction

   task automatic write_register(csr_index_type index, logic [WORD_W-1:0] value, int width);
      logic [WORD_W-1:0] word;
      word = $urandom;
      for (int b = 0; b < width; b++)
         word[b] = value[b];
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = word;
   endtask

   task automatic load_view(sky_view_type v);
      write_register(CSR_VIEW_X, v.view_x, WORD_W);
      write_register(CSR_VIEW_Y, v.view_y, WORD_W);
      write_register(CSR_VIEW_SINE, WORD_W'(v.sine), TRIG_W);
      write_register(CSR_VIEW_COSINE, WORD_W'(v.cosine), TRIG_W);
      write_register(CSR_DRIFT_X, v.drift_x, WORD_W);
      write_register(CSR_DRIFT_Y, v.drift_y, WORD_W);
      write_register(CSR_PROJECTION_SCALE, WORD_W'(v.scale), SCALE_W);
      write_register(CSR_CENTER_COLUMN, WORD_W'(v.center), 10);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_request(logic [9:0] column, logic [8:0] row_height, bit typed,
                               logic [TEXEL_W-1:0] texel);
      int gap;
      if (stall_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {5'd0, row_height, column};
      req_typed = typed;
      req_typed_texel = texel;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (texel_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_random(logic [9:0] center);
      logic [9:0] column;
      logic [8:0] row_height;
      column = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 3) == 0)
         column = center + 10'($urandom_range(0, 6)) - 10'd3;
      row_height = 9'($urandom_range(1, 511));
      case ($urandom_range(0, 15))
         0: row_height = 9'd0;
         1: row_height = 9'd1;
         2: row_height = 9'd511;
         3: row_height = 9'($urandom_range(1, 8));
         default: ;
      endcase
      send_request(column, row_height, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         view_copy <= default_view();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_VIEW_X:           view_copy.view_x  <= csr_wdata;
               CSR_VIEW_Y:           view_copy.view_y  <= csr_wdata;
               CSR_VIEW_SINE:        view_copy.sine    <= csr_wdata[TRIG_W-1:0];
               CSR_VIEW_COSINE:      view_copy.cosine  <= csr_wdata[TRIG_W-1:0];
               CSR_DRIFT_X:          view_copy.drift_x <= csr_wdata;
               CSR_DRIFT_Y:          view_copy.drift_y <= csr_wdata;
               CSR_PROJECTION_SCALE: view_copy.scale   <= csr_wdata[SCALE_W-1:0];
               CSR_CENTER_COLUMN:    view_copy.center  <= csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_typed)
               texel_queue.push_back(req_typed_texel);
            else
               texel_queue.push_back(texel_of(view_copy, req_tdata[9:0], req_tdata[18:10]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (texel_queue.size() == 0) begin
               $display("%0t: unexpected texel index, expected none, got %04h",
                        $time, rsp_tdata);
               fault_count++;
            end else if (rsp_tdata !== texel_queue[0]) begin
               $display("%0t: texel index mismatch, expected %04h, got %04h",
                        $time, texel_queue[0], rsp_tdata);
               fault_count++;
               void'(texel_queue.pop_front());
            end else begin
               void'(texel_queue.pop_front());
            end
         end
      end
   end

   initial begin
      bit choke_taken;
      int burst;
      choke_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (choke_request && !choke_taken) begin
            rsp_tready = 1'b0;
            choke_taken = 1'b1;
            repeat (HOLD_OFF - 1) @(negedge clock);
         end else if (stall_enable && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            burst = int'($urandom_range(1, 15));
            for (int c = 1; c < burst && stall_enable; c++)
               @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sky_view_type v;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_typed = 1'b0;
      req_typed_texel = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_enable = 1'b1;
      choke_request = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (probe_table[i])
         send_request(probe_table[i].column, probe_table[i].row_height,
                      probe_table[i].typed, probe_table[i].texel);
      drain();

      for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
         if (phase <= 3)
            v = fixed_view(phase);
         else
            v = random_view();
         stall_enable = (phase != PHASE_COUNT) && (phase != CHOKE_PHASE) &&
                        ($urandom_range(0, 3) != 0);
         load_view(v);
         if (phase == CHOKE_PHASE)
            choke_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random(v.center);
         drain();
      end

      repeat (PIPE_DEPTH + 8) @(negedge clock);
      if (fault_count == 0 && texel_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
